// ===== hdl/sfa_pkg.sv =====
`timescale 1ns / 1ps

package sfa_pkg;

    localparam int VertexDepthDefault = 4096;
    localparam int CmdW   = 2;
    localparam int IdxW   = 12;
    localparam int CoordW = 32;
    localparam int NormW  = 32;
    // Slot numbers cover the largest supported store (65536 entries)
    localparam int SlotW  = 16;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_CONT  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        JOB_LOAD = 2'd0,
        JOB_OVF  = 2'd1,
        JOB_FACE = 2'd2
    } job_kind_t;

    typedef struct packed {
        logic [IdxW-1:0] a;
        logic [IdxW-1:0] b;
        logic [IdxW-1:0] c;
    } tri_t;

    typedef struct packed {
        job_kind_t                 kind;
        logic [SlotW-1:0]          slot;
        logic signed [CoordW-1:0]  x;
        logic signed [CoordW-1:0]  y;
        logic signed [CoordW-1:0]  z;
        tri_t                      f0;
        tri_t                      f1;
        logic                      two;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_READ,
        BK_MUL,
        BK_ABS,
        BK_NORM,
        BK_SQ,
        BK_SQRT,
        BK_DINIT,
        BK_DIV,
        BK_DONE
    } bk_state_t;

endpackage

// ===== hdl/sfa_if.sv =====
`timescale 1ns / 1ps

interface sfa_req_if;
    import sfa_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CmdW-1:0]          command;
    logic [IdxW-1:0]          index_a;
    logic [IdxW-1:0]          index_b;
    logic [IdxW-1:0]          index_c;
    logic [IdxW-1:0]          index_d;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;

    modport source (output valid, command, index_a, index_b, index_c, index_d,
                    coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, command, index_a, index_b, index_c, index_d,
                    coord_x, coord_y, coord_z, output ready);
endinterface

interface sfa_rsp_if;
    import sfa_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IdxW-1:0]         face_a;
    logic [IdxW-1:0]         face_b;
    logic [IdxW-1:0]         face_c;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic                    degenerate;
    logic                    overflow;
    logic                    last;

    modport source (output valid, face_a, face_b, face_c, normal_x, normal_y,
                    normal_z, degenerate, overflow, last, input ready);
    modport sink   (input valid, face_a, face_b, face_c, normal_x, normal_y,
                    normal_z, degenerate, overflow, last, output ready);
endinterface

// ===== hdl/strip_face_assembler_unit.sv =====
`timescale 1ns / 1ps

// Triangle-strip face assembler with flat unit normals. Items on req are
// vertex loads (stored in slots 1, 2, ... in arrival order; a load into a
// full store is dropped and answered with one overflow item), strip starts
// and strip continues; each strip item gives one or two face items on rsp
// with indices in winding order, a Q2.30 unit normal and a degenerate flag,
// and last marks the final face of the item. A load is written into the
// store from the back end's idle state. A face takes three vertex reads,
// one at a time, a cross product on the shared 32x32 multiplier (a zero
// result ends a degenerate face there), normalization, the sum of
// squares, the square root at one result bit per cycle, and the three
// divisions that run side by side at one quotient bit per cycle. The front
// end takes a new item each cycle until its two-entry job queue is full,
// and a finished face waits in the output register while the next is built.
module strip_face_assembler_unit #(
    parameter int VERTEX_DEPTH = sfa_pkg::VertexDepthDefault
) (
    input  logic      clk,
    input  logic      rst_n,
    sfa_req_if.sink   req,
    sfa_rsp_if.source rsp
);
    import sfa_pkg::*;

    job_t    push_job;
    job_t    head_job;
    q_ctl_t  q_ctl;
    q_stat_t q_stat;

    // front: decode the item, track strip winding and the fill count
    sfa_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .job   (push_job),
        .push  (q_ctl.push),
        .full  (q_stat.full)
    );

    // hold up to two jobs so either side can stall alone
    sfa_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (q_ctl),
        .wr_job (push_job),
        .rd_job (head_job),
        .stat   (q_stat)
    );

    // back: own the vertex store, build faces and normals
    sfa_back #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head_job),
        .empty (q_stat.empty),
        .pop   (q_ctl.pop),
        .rsp   (rsp)
    );

endmodule

// ===== hdl/sfa_front.sv =====
`timescale 1ns / 1ps

module sfa_front #(
    parameter int VERTEX_DEPTH = sfa_pkg::VertexDepthDefault
) (
    input  logic            clk,
    input  logic            rst_n,
    sfa_req_if.sink         req,
    output sfa_pkg::job_t   job,
    output logic            push,
    input  logic            full
);
    import sfa_pkg::*;

    localparam int CntW = $clog2(VERTEX_DEPTH + 1);

    logic [CntW-1:0] count_reg, count_next;
    logic [IdxW-1:0] prev_first_reg, prev_first_next;
    logic [IdxW-1:0] prev_second_reg, prev_second_next;
    logic            odd_reg, odd_next;
    logic            accept;

    assign req.ready = !full;
    assign accept    = req.valid && !full;

    always_comb
    begin
        count_next       = count_reg;
        prev_first_next  = prev_first_reg;
        prev_second_next = prev_second_reg;
        odd_next         = odd_reg;
        push             = 1'b0;
        job              = '0;
        job.kind         = JOB_FACE;
        job.x            = req.coord_x;
        job.y            = req.coord_y;
        job.z            = req.coord_z;
        job.slot         = SlotW'(count_reg);
        unique case (cmd_t'(req.command))
            CMD_LOAD:
            begin
                push = accept;
                if (count_reg >= CntW'(VERTEX_DEPTH))
                begin
                    job.kind = JOB_OVF;
                end
                else
                begin
                    job.kind = JOB_LOAD;
                    if (accept)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            CMD_START:
            begin
                push    = accept;
                job.f0  = '{a: req.index_a, b: req.index_b, c: req.index_c};
                job.f1  = '{a: req.index_c, b: req.index_b, c: req.index_d};
                job.two = (req.index_d != '0);
                if (accept)
                begin
                    odd_next         = job.two;
                    prev_first_next  = job.two ? req.index_c : req.index_b;
                    prev_second_next = job.two ? req.index_d : req.index_c;
                end
            end
            CMD_CONT:
            begin
                push    = accept;
                job.two = (req.index_b != '0);
                // winding flips on every strip face
                if (odd_reg)
                begin
                    job.f0 = '{a: prev_first_reg, b: prev_second_reg, c: req.index_a};
                    job.f1 = '{a: req.index_a, b: prev_second_reg, c: req.index_b};
                end
                else
                begin
                    job.f0 = '{a: prev_second_reg, b: prev_first_reg, c: req.index_a};
                    job.f1 = '{a: prev_second_reg, b: req.index_a, c: req.index_b};
                end
                if (accept)
                begin
                    if (job.two)
                    begin
                        prev_first_next  = req.index_a;
                        prev_second_next = req.index_b;
                    end
                    else
                    begin
                        odd_next         = !odd_reg;
                        prev_first_next  = prev_second_reg;
                        prev_second_next = req.index_a;
                    end
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= CntW'(1);
            prev_first_reg  <= '0;
            prev_second_reg <= '0;
            odd_reg         <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            prev_first_reg  <= prev_first_next;
            prev_second_reg <= prev_second_next;
            odd_reg         <= odd_next;
        end
    end

endmodule

// ===== hdl/sfa_queue.sv =====
`timescale 1ns / 1ps

module sfa_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  sfa_pkg::q_ctl_t  ctl,
    input  sfa_pkg::job_t    wr_job,
    output sfa_pkg::job_t    rd_job,
    output sfa_pkg::q_stat_t stat
);
    import sfa_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    job_t            slot_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   fill_reg;
    logic            do_push, do_pop;

    assign stat.full  = (fill_reg == (PtrW+1)'(QueueDepth));
    assign stat.empty = (fill_reg == '0);
    assign do_push    = ctl.push && !stat.full;
    assign do_pop     = ctl.pop && !stat.empty;
    assign rd_job     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
        end
    end

endmodule

// ===== hdl/sfa_back.sv =====
`timescale 1ns / 1ps

module sfa_back #(
    parameter int VERTEX_DEPTH = sfa_pkg::VertexDepthDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sfa_pkg::job_t head,
    input  logic          empty,
    output logic          pop,
    sfa_rsp_if.source     rsp
);
    import sfa_pkg::*;

    localparam int AW   = $clog2(VERTEX_DEPTH);
    localparam int ExtW = 17;

    bk_state_t state_reg, state_next;
    logic [5:0] step_reg;
    logic       face_sel_reg;
    job_t       job_reg;

    logic [3*CoordW-1:0] mem [VERTEX_DEPTH];
    logic [3*CoordW-1:0] rd_data_reg;
    logic                rd_oor_reg;
    logic                mem_we, mem_re, rd_oor;
    logic [AW-1:0]       rd_addr;
    logic [ExtW-1:0]     rd_ext;
    logic [IdxW-1:0]     rd_idx;

    logic signed [CoordW-1:0] vtx_reg [3][3];
    logic signed [CoordW:0]   du [3];
    logic signed [CoordW:0]   dv [3];
    logic signed [CoordW:0]   opa, opb;
    logic [CoordW-1:0]        ma, mb;
    logic [2*CoordW-1:0]      pm;
    logic signed [65:0]       prod_reg, prod_next;
    logic signed [65:0]       cross_reg [3];
    logic [64:0]              mag_reg [3];
    logic                     neg_reg [3];
    logic [64:0]              mor;
    logic                     aligned, zero_cross;

    logic [61:0] sq_reg;
    logic [63:0] sum_reg, x_reg, r_reg, bit_reg, root_t;
    logic [31:0] len_reg;
    logic [61:0] num_init [3];
    logic [31:0] rem_reg [3];
    logic [30:0] num_reg [3];
    logic [30:0] quo_reg [3];
    logic [32:0] rem2 [3];

    logic res_deg_reg;
    logic out_valid_reg, out_free, out_load, is_ovf;
    tri_t cur;
    logic signed [NormW-1:0] nrm [3];

    assign cur      = face_sel_reg ? job_reg.f1 : job_reg.f0;
    assign out_free = !out_valid_reg || rsp.ready;
    assign is_ovf   = (job_reg.kind == JOB_OVF);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    if (head.kind == JOB_FACE)
                    begin
                        state_next = BK_READ;
                    end
                    else if (head.kind == JOB_OVF)
                    begin
                        state_next = BK_DONE;
                    end
                end
            end
            BK_READ:  if (step_reg == 6'd3) state_next = BK_MUL;
            BK_MUL:   if (step_reg == 6'd6) state_next = BK_ABS;
            BK_ABS:   state_next = zero_cross ? BK_DONE : BK_NORM;
            BK_NORM:  if (aligned) state_next = BK_SQ;
            BK_SQ:    if (step_reg == 6'd3) state_next = BK_SQRT;
            BK_SQRT:  if (step_reg == 6'd31) state_next = BK_DINIT;
            BK_DINIT: state_next = BK_DIV;
            BK_DIV:   if (step_reg == 6'd30) state_next = BK_DONE;
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = (!is_ovf && job_reg.two && !face_sel_reg) ? BK_READ : BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        pop      = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        out_load = 1'b0;
        rd_idx   = cur.a;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop    = !empty;
                mem_we = !empty && (head.kind == JOB_LOAD);
            end
            BK_READ:
            begin
                mem_re = (step_reg != 6'd3);
                case (step_reg[1:0])
                    2'd0:    rd_idx = cur.a;
                    2'd1:    rd_idx = cur.b;
                    default: rd_idx = cur.c;
                endcase
            end
            BK_DONE:  out_load = out_free;
            default:  pop = 1'b0;
        endcase
    end

    assign rd_ext  = ExtW'(rd_idx);
    assign rd_oor  = (rd_ext >= ExtW'(VERTEX_DEPTH));
    assign rd_addr = rd_ext[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[head.slot[AW-1:0]] <= {head.x, head.y, head.z};
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_oor_reg  <= rd_oor;
        end
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            du[i] = {vtx_reg[1][i][CoordW-1], vtx_reg[1][i]}
                  - {vtx_reg[0][i][CoordW-1], vtx_reg[0][i]};
            dv[i] = {vtx_reg[2][i][CoordW-1], vtx_reg[2][i]}
                  - {vtx_reg[0][i][CoordW-1], vtx_reg[0][i]};
        end
        case (step_reg[2:0])
            3'd0:    begin opa = du[1]; opb = dv[2]; end
            3'd1:    begin opa = du[2]; opb = dv[1]; end
            3'd2:    begin opa = du[2]; opb = dv[0]; end
            3'd3:    begin opa = du[0]; opb = dv[2]; end
            3'd4:    begin opa = du[0]; opb = dv[1]; end
            default: begin opa = du[1]; opb = dv[0]; end
        endcase
        ma = opa[CoordW] ? CoordW'(-opa) : CoordW'(opa);
        mb = opb[CoordW] ? CoordW'(-opb) : CoordW'(opb);
        pm = ma * mb;
        prod_next = (opa[CoordW] ^ opb[CoordW]) ? -$signed({2'b00, pm}) : $signed({2'b00, pm});

        zero_cross = (cross_reg[0] == '0) && (cross_reg[1] == '0) && (cross_reg[2] == '0);
        mor        = mag_reg[0] | mag_reg[1] | mag_reg[2];
        aligned    = (mor[64:31] == '0) && mor[30];
        root_t     = r_reg + bit_reg;

        for (int i = 0; i < 3; i++)
        begin
            num_init[i] = {mag_reg[i][30:0], 30'd0} + 62'(len_reg[31:1]);
            rem2[i]     = {rem_reg[i], num_reg[i][30]};
            nrm[i]      = neg_reg[i] ? -$signed({1'b0, quo_reg[i]}) : $signed({1'b0, quo_reg[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                job_reg     <= head;
                res_deg_reg <= 1'b0;
            end
            BK_READ:
            begin
                // read data is registered and arrives in the cycle after its address
                if (step_reg != 6'd0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (step_reg[1:0] == 2'(i + 1))
                        begin
                            vtx_reg[i][0] <= rd_oor_reg ? '0 : rd_data_reg[3*CoordW-1:2*CoordW];
                            vtx_reg[i][1] <= rd_oor_reg ? '0 : rd_data_reg[2*CoordW-1:CoordW];
                            vtx_reg[i][2] <= rd_oor_reg ? '0 : rd_data_reg[CoordW-1:0];
                        end
                    end
                end
                res_deg_reg <= 1'b0;
            end
            BK_MUL:
            begin
                prod_reg <= prod_next;
                case (step_reg[2:0])
                    3'd1:    cross_reg[0] <= prod_reg;
                    3'd2:    cross_reg[0] <= cross_reg[0] - prod_reg;
                    3'd3:    cross_reg[1] <= prod_reg;
                    3'd4:    cross_reg[1] <= cross_reg[1] - prod_reg;
                    3'd5:    cross_reg[2] <= prod_reg;
                    3'd6:    cross_reg[2] <= cross_reg[2] - prod_reg;
                    default: ;
                endcase
            end
            BK_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= cross_reg[i][65] ? 65'(-cross_reg[i]) : 65'(cross_reg[i]);
                    neg_reg[i] <= cross_reg[i][65];
                end
                res_deg_reg <= zero_cross;
            end
            BK_NORM:
            begin
                // move the largest magnitude into [2^30, 2^31)
                for (int i = 0; i < 3; i++)
                begin
                    if (mor[64:39] != '0)
                        mag_reg[i] <= mag_reg[i] >> 8;
                    else if (mor[38:31] != '0)
                        mag_reg[i] <= mag_reg[i] >> 1;
                    else if (mor[30:23] == '0)
                        mag_reg[i] <= mag_reg[i] << 8;
                    else if (!mor[30])
                        mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            BK_SQ:
            begin
                case (step_reg[1:0])
                    2'd0:    sq_reg <= mag_reg[0][30:0] * mag_reg[0][30:0];
                    2'd1:    sq_reg <= mag_reg[1][30:0] * mag_reg[1][30:0];
                    2'd2:    sq_reg <= mag_reg[2][30:0] * mag_reg[2][30:0];
                    default: sq_reg <= sq_reg;
                endcase
                if (step_reg == 6'd1)
                    sum_reg <= 64'(sq_reg);
                else if (step_reg == 6'd2)
                    sum_reg <= sum_reg + 64'(sq_reg);
                x_reg   <= sum_reg + 64'(sq_reg);
                r_reg   <= '0;
                bit_reg <= 64'd1 << 62;
            end
            BK_SQRT:
            begin
                if (x_reg >= root_t)
                begin
                    x_reg <= x_reg - root_t;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                len_reg <= 32'((r_reg >> 1) + ((x_reg >= root_t) ? bit_reg : 64'd0));
            end
            BK_DINIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= 32'(num_init[i][61:31]);
                    num_reg[i] <= num_init[i][30:0];
                    quo_reg[i] <= '0;
                end
            end
            BK_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem2[i] >= {1'b0, len_reg})
                    begin
                        rem_reg[i] <= 32'(rem2[i] - {1'b0, len_reg});
                        quo_reg[i] <= {quo_reg[i][29:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i] <= rem2[i][31:0];
                        quo_reg[i] <= {quo_reg[i][29:0], 1'b0};
                    end
                    num_reg[i] <= {num_reg[i][29:0], 1'b0};
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp.face_a     <= is_ovf ? '0 : cur.a;
            rsp.face_b     <= is_ovf ? '0 : cur.b;
            rsp.face_c     <= is_ovf ? '0 : cur.c;
            rsp.normal_x   <= (is_ovf || res_deg_reg) ? '0 : nrm[0];
            rsp.normal_y   <= (is_ovf || res_deg_reg) ? '0 : nrm[1];
            rsp.normal_z   <= (is_ovf || res_deg_reg) ? '0 : nrm[2];
            rsp.degenerate <= !is_ovf && res_deg_reg;
            rsp.overflow   <= is_ovf;
            rsp.last       <= is_ovf || !job_reg.two || face_sel_reg;
        end
    end

    assign rsp.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            face_sel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? '0 : step_reg + 1'b1;
            if (state_reg == BK_IDLE)
                face_sel_reg <= 1'b0;
            else if (state_reg == BK_DONE && state_next == BK_READ)
                face_sel_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
